@@ hdl/sbsh_pkg.sv @@
// package for the sha-256 byte stream hasher: codes, control types and round constants
`default_nettype none
package sbsh_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND     = 2'd0,
    CMD_APPEND_FIN = 2'd1,
    CMD_FINISH     = 2'd2
  } sbsh_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } sbsh_state_t;

  typedef struct packed {
    logic shift;
    logic pad_sel;
    logic pad_mark;
    logic pad_len;
    logic count_len;
    logic start_blk;
    logic round;
    logic h_update;
    logic load_out;
  } sbsh_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_tail;
    logic round_last;
    logic out_busy;
  } sbsh_stat_t;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    round_k = K_TAB[t];
  endfunction

endpackage
`default_nettype wire

@@ hdl/sbsh_ctrl.sv @@
// controller state machine: byte intake, padding sequence, compression and digest hand-off
`default_nettype none
module sbsh_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_cmd,
  input  wire sbsh_pkg::sbsh_stat_t stat,
  output logic                    in_ready,
  output sbsh_pkg::sbsh_cmd_t     cmd,
  output sbsh_pkg::sbsh_state_t   st
);
  import sbsh_pkg::*;

  sbsh_state_t state_r, state_nxt;
  logic fin_r, fin_nxt;
  logic mark_r, mark_nxt;
  logic lenblk_r, lenblk_nxt;
  logic lastblk_r, lastblk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fin_r     <= 1'b0;
      mark_r    <= 1'b0;
      lenblk_r  <= 1'b0;
      lastblk_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fin_r     <= fin_nxt;
      mark_r    <= mark_nxt;
      lenblk_r  <= lenblk_nxt;
      lastblk_r <= lastblk_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    fin_nxt     = fin_r;
    mark_nxt    = mark_r;
    lenblk_nxt  = lenblk_r;
    lastblk_nxt = lastblk_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_APPEND: begin
              fin_nxt     = 1'b0;
              lastblk_nxt = 1'b0;
              if (stat.fill_last) state_nxt = ST_ROUND;
            end
            CMD_APPEND_FIN: begin
              fin_nxt     = 1'b1;
              mark_nxt    = 1'b0;
              lastblk_nxt = 1'b0;
              state_nxt   = stat.fill_last ? ST_ROUND : ST_PAD;
            end
            CMD_FINISH: begin
              fin_nxt   = 1'b1;
              mark_nxt  = 1'b0;
              state_nxt = ST_PAD;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        if (!mark_r) begin
          mark_nxt   = 1'b1;
          lenblk_nxt = !stat.fill_tail;
        end
        if (stat.fill_last) begin
          lastblk_nxt = mark_r && lenblk_r;
          state_nxt   = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (stat.round_last) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (lastblk_r) begin
          state_nxt = ST_OUT;
        end else begin
          lenblk_nxt = 1'b1;
          state_nxt  = ST_PAD;
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          fin_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_cmd == CMD_APPEND || in_cmd == CMD_APPEND_FIN)) begin
          cmd.shift     = 1'b1;
          cmd.count_len = 1'b1;
          cmd.start_blk = stat.fill_last;
        end
      end
      ST_PAD: begin
        cmd.shift     = 1'b1;
        cmd.pad_sel   = 1'b1;
        cmd.pad_mark  = !mark_r;
        cmd.pad_len   = mark_r && lenblk_r && stat.fill_tail;
        cmd.start_blk = stat.fill_last;
      end
      ST_ROUND:  cmd.round    = 1'b1;
      ST_UPDATE: cmd.h_update = 1'b1;
      ST_OUT:    cmd.load_out = !stat.out_busy;
      default: ;
    endcase
  end

  assign st = state_r;

endmodule
`default_nettype wire

@@ hdl/sbsh_dp.sv @@
// datapath: schedule window, round unit, hash words, length counter and digest buffer
`default_nettype none
module sbsh_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sbsh_pkg::sbsh_cmd_t cmd,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                out_ready,
  output sbsh_pkg::sbsh_stat_t     stat,
  output logic                     out_valid,
  output logic [31:0]              out_digest_word,
  output logic [2:0]               out_word_index,
  output logic                     out_last_word
);
  import sbsh_pkg::*;

  logic [511:0] w_r;
  logic [31:0]  v_r [8];
  logic [31:0]  h_r [8];
  logic [31:0]  obuf_r [8];
  logic [5:0]   fill_r;
  logic [5:0]   rnd_r;
  logic [63:0]  len_r;
  logic [3:0]   ocnt_r;
  logic [2:0]   oidx_r;

  logic [7:0]  len_byte;
  logic [7:0]  new_byte;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] s0, s1, big0, big1, choose, major, t1, t2;
  logic        out_take;

  assign len_byte = len_r[{~fill_r[2:0], 3'b000} +: 8];
  assign new_byte = !cmd.pad_sel ? in_data_byte :
                    cmd.pad_mark ? PAD_MARK :
                    cmd.pad_len  ? len_byte : 8'h00;

  assign w0  = w_r[511:480];
  assign w1  = w_r[479:448];
  assign w9  = w_r[223:192];
  assign w14 = w_r[63:32];
  assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  assign big1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign choose = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1     = v_r[7] + big1 + choose + round_k(rnd_r) + w0;
  assign big0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign major  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2     = big0 + major;

  assign out_take = out_valid && out_ready;

  // window, working variables and output buffer shift
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      w_r <= {w_r[503:0], new_byte};
    end else if (cmd.round) begin
      w_r <= {w_r[479:0], w_new};
    end
    if (cmd.start_blk) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (cmd.load_out) begin
      for (int i = 0; i < 8; i++) obuf_r[i] <= h_r[i];
    end else if (out_take) begin
      for (int i = 0; i < 7; i++) obuf_r[i] <= obuf_r[i + 1];
    end
  end

  // control-carrying registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
      fill_r <= '0;
      rnd_r  <= '0;
      len_r  <= '0;
      ocnt_r <= '0;
      oidx_r <= '0;
    end else begin
      if (cmd.shift) fill_r <= fill_r + 6'd1;
      if (cmd.count_len) len_r <= len_r + 64'd8;
      if (cmd.start_blk) begin
        rnd_r <= '0;
      end else if (cmd.round) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.h_update) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end else if (cmd.load_out) begin
        for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
      end
      if (cmd.load_out) begin
        len_r  <= '0;
        fill_r <= '0;
        ocnt_r <= 4'd8;
        oidx_r <= '0;
      end else if (out_take) begin
        ocnt_r <= ocnt_r - 4'd1;
        oidx_r <= oidx_r + 3'd1;
      end
    end
  end

  assign stat.fill_last  = (fill_r == 6'd63);
  assign stat.fill_tail  = (fill_r[5:3] == 3'd7);
  assign stat.round_last = (rnd_r == 6'd63);
  assign stat.out_busy   = (ocnt_r != 4'd0);

  assign out_valid       = (ocnt_r != 4'd0);
  assign out_digest_word = obuf_r[0];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

endmodule
`default_nettype wire

@@ hdl/sha256_byte_stream_hasher.sv @@
// top level of the sha-256 byte stream hasher
// usage:
//   each input request carries a command and one byte: append the byte, append it and
//   close the message, or close the message with no byte. a fourth code is dropped.
//   a byte is taken whenever in_valid and in_ready are both high; the 64th byte of a block
//   starts the compression, which runs one round per cycle and then folds the result
//   into the hash words. the single round unit limits the block rate.
//   closing a message shifts padding and the 64-bit length in one byte per cycle,
//   with one or two compressions, then copies the digest into an eight-word output
//   buffer and re-arms for the next message.
//   the result channel then presents the eight digest words, index 0 first, the last
//   flagged by out_last_word. the output buffer parts the two sides: new bytes are
//   taken while the digest drains; only a following close waits for the buffer to
//   empty, so a stalled receiver holds the next digest back and nothing is lost.
//   in_ready is low during padding and compression.
//   reset (rst_n low, synchronous) loads the initial hash values and clears the
//   byte count, bit length and output buffer.
`default_nettype none
module sha256_byte_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import sbsh_pkg::*;

  sbsh_cmd_t   cmd;
  sbsh_stat_t  stat;
  sbsh_state_t st;

  sbsh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  sbsh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data_byte    (in_data_byte),
    .out_ready       (out_ready),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  a_finish_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_FINISH |=> !in_ready)
    else $error("close request did not stop intake");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    st == ST_ROUND && stat.round_last |=> st == ST_UPDATE)
    else $error("last round not followed by hash update");

  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid)
    else $error("digest loaded over a pending digest");

  a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid && out_word_index == 3'd0)
    else $error("digest load did not present word zero");

endmodule
`default_nettype wire
